### hw/rtl/lsstm_pkg.sv
// ----------------------------------------------------------------------------
// lsstm_pkg
// Shared types, register codes and small constant dividers for the
// stream/segment parser and tone mapper address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lsstm_pkg;

	localparam int MAX_STREAMS    = 4;
	localparam int MAX_DATA_TONES = 468;

	typedef logic [12:0] pos_t;

	typedef enum logic [2:0] {
		REG_STREAM_COUNT = 3'd0,
		REG_TONE_BITS0   = 3'd1,
		REG_TONE_BITS1   = 3'd2,
		REG_TONE_BITS2   = 3'd3,
		REG_TONE_BITS3   = 3'd4,
		REG_BAND_MODE    = 3'd5,
		REG_DATA_TONES   = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		BAND_HT     = 3'd0,
		BAND_VHT20  = 3'd1,
		BAND_VHT40  = 3'd2,
		BAND_VHT80  = 3'd3,
		BAND_VHT160 = 3'd4
	} band_t;

	// control that rides along the pipeline
	typedef struct packed {
		logic [1:0] q;
		logic       sub;
		logic       err;
	} lane_t;

	// x / dv for dv in {1,2,3,4,5,6,8,9,10}; reciprocal multiplies, exact for x < 8192
	function automatic pos_t div_const(input pos_t x, input logic [3:0] dv);
		logic [29:0] m3;
		logic [29:0] m5;
		logic [29:0] m9;
		pos_t        r;
		m3 = {17'd0, x} * 30'd43691;
		m5 = {17'd0, x} * 30'd52429;
		m9 = {17'd0, x} * 30'd58255;
		case (dv)
			4'd2:    r = x >> 1;
			4'd3:    r = 13'(m3 >> 17);
			4'd4:    r = x >> 2;
			4'd5:    r = 13'(m5 >> 18);
			4'd6:    r = 13'(m3 >> 18);
			4'd8:    r = x >> 3;
			4'd9:    r = 13'(m9 >> 19);
			4'd10:   r = 13'(m5 >> 19);
			default: r = x;
		endcase
		return r;
	endfunction

	// stream parser block size max(1, bits/2)
	function automatic logic [2:0] blk(input logic [3:0] b);
		return (b < 4'd2) ? 3'd1 : 3'(b >> 1);
	endfunction

	function automatic logic bits_ok(input logic [3:0] b);
		return (b == 4'd1) || (b == 4'd2) || (b == 4'd4) || (b == 4'd6) ||
			(b == 4'd8) || (b == 4'd10);
	endfunction

endpackage

`default_nettype wire

### hw/rtl/ldpc_stream_segment_tone_mapper.sv
// ----------------------------------------------------------------------------
// ldpc_stream_segment_tone_mapper
// LDPC transmit bit-mapping address generator: undoes tone mapper, 160 MHz
// segment parser and stream parser to find a coded bit's source index.
// ----------------------------------------------------------------------------
// Pipeline: 10 register stages, s1 to s10; m_tvalid is the valid bit of
// the last stage, so a result transfers from the s10 register.
// Throughput: one transfer per cycle; each stage holds only when the stage
// after it is full and stalled, so bubbles collapse and input keeps flowing
// while a result waits at the output register.
// Reset: arst_n clears all valid bits and loads the register defaults
// (1 stream, 1 bit per tone, VHT20, 52 tones).
`default_nettype none

module ldpc_stream_segment_tone_mapper (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [1:0] stream_select, [14:2] mapped_position
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [14:0] source_index
	output logic             m_tuser,   // [0] mapping_error
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import lsstm_pkg::*;

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	logic [2:0] stream_count_q;
	logic [3:0] tone_bits_q [MAX_STREAMS];
	logic [2:0] band_mode_q;
	logic [8:0] data_tone_count_q;

	logic     wr_en;
	reg_idx_t wr_idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign wr_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_count_q    <= 3'd1;
			tone_bits_q[0]    <= 4'd1;
			tone_bits_q[1]    <= 4'd1;
			tone_bits_q[2]    <= 4'd1;
			tone_bits_q[3]    <= 4'd1;
			band_mode_q       <= BAND_VHT20;
			data_tone_count_q <= 9'd52;
		end else if (wr_en) begin
			case (wr_idx)
				REG_STREAM_COUNT: stream_count_q    <= pwdata[2:0];
				REG_TONE_BITS0:   tone_bits_q[0]    <= pwdata[3:0];
				REG_TONE_BITS1:   tone_bits_q[1]    <= pwdata[3:0];
				REG_TONE_BITS2:   tone_bits_q[2]    <= pwdata[3:0];
				REG_TONE_BITS3:   tone_bits_q[3]    <= pwdata[3:0];
				REG_BAND_MODE:    band_mode_q       <= pwdata[2:0];
				REG_DATA_TONES:   data_tone_count_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (wr_idx)
			REG_STREAM_COUNT: prdata = {29'd0, stream_count_q};
			REG_TONE_BITS0:   prdata = {28'd0, tone_bits_q[0]};
			REG_TONE_BITS1:   prdata = {28'd0, tone_bits_q[1]};
			REG_TONE_BITS2:   prdata = {28'd0, tone_bits_q[2]};
			REG_TONE_BITS3:   prdata = {28'd0, tone_bits_q[3]};
			REG_BAND_MODE:    prdata = {29'd0, band_mode_q};
			REG_DATA_TONES:   prdata = {23'd0, data_tone_count_q};
			default:          prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Settings-derived values. The user must change registers only while
	// idle (not enforced), so these are static over an item's life.
	// ------------------------------------------------------------------
	logic [3:0] tone_dist;
	logic [8:0] tones;
	logic [8:0] cols;
	logic       div_ok;
	logic       cfg_ok;
	logic [3:0] prefix [MAX_STREAMS];
	logic [4:0] pblock;
	pos_t       lim    [MAX_STREAMS];

	always_comb begin
		case (band_mode_q)
			BAND_VHT20:  tone_dist = 4'd4;
			BAND_VHT40:  tone_dist = 4'd6;
			BAND_VHT80,
			BAND_VHT160: tone_dist = 4'd9;
			default:     tone_dist = 4'd1;
		endcase
		tones  = (band_mode_q == BAND_VHT160) ? (data_tone_count_q >> 1) : data_tone_count_q;
		cols   = 9'(div_const({4'd0, tones}, tone_dist));
		// tone count must split into whole columns; VHT160 halves must be equal
		div_ok = (13'(cols * tone_dist) == {4'd0, tones}) &&
			((band_mode_q != BAND_VHT160) || !data_tone_count_q[0]);
		cfg_ok = (stream_count_q >= 3'd1) && (stream_count_q <= 3'(MAX_STREAMS)) &&
			(data_tone_count_q >= 9'd1) && (data_tone_count_q <= 9'(MAX_DATA_TONES)) &&
			(band_mode_q <= BAND_VHT160) && div_ok;
		pblock = 5'd0;
		for (int i = 0; i < MAX_STREAMS; i++) begin
			prefix[i] = 4'(pblock);
			if (3'(i) < stream_count_q) begin
				if (!bits_ok(tone_bits_q[i]))
					cfg_ok = 1'b0;
				pblock = pblock + 5'(blk(tone_bits_q[i]));
			end
			lim[i] = 13'(data_tone_count_q * tone_bits_q[i]);
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control: a stage loads when empty or when the next one moves
	// ------------------------------------------------------------------
	localparam int NS = 10;
	logic [NS:1] v;
	logic [NS:1] en;

	always_comb begin
		en[NS] = !v[NS] | m_tready;
		for (int i = NS - 1; i >= 1; i--)
			en[i] = !v[i] | en[i+1];
	end

	assign s_tready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[1])
				v[1] <= s_tvalid;
			for (int i = 2; i <= NS; i++) begin
				if (en[i])
					v[i] <= v[i-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Datapath
	// ------------------------------------------------------------------
	lane_t ln_s1, ln_s2, ln_s3, ln_s4, ln_s5, ln_s6, ln_s7, ln_s8, ln_s9, ln_s10;
	pos_t  p_s1, p_s2, p_s3, p_s4, p_s5;
	pos_t  u_s2, u_s3;
	pos_t  ud_s3, ud_s4;
	logic [3:0] bit_s3, bit_s4, bit_s5;
	logic [3:0] um_s4;
	pos_t  t_s5;
	pos_t  j_s6, j_s7;
	pos_t  js_s7;
	pos_t  k_s8, k_s9;
	pos_t  ks_s9;
	logic [14:0] idx_s10;

	logic [1:0] in_q;
	pos_t       in_p;
	pos_t       in_lim;
	logic       in_sub;

	assign in_q   = s_tdata[1:0];
	assign in_p   = s_tdata[14:2];
	assign in_lim = lim[in_q];
	assign in_sub = (band_mode_q == BAND_VHT160) && (in_p >= (in_lim >> 1));

	// per-stage tone bits and block size of the item's stream
	logic [3:0] b2, b3, b6;
	logic [2:0] sz7, sz8, sz9, sz10;
	assign b2   = tone_bits_q[ln_s1.q];
	assign b3   = tone_bits_q[ln_s2.q];
	assign b6   = tone_bits_q[ln_s5.q];
	assign sz7  = blk(tone_bits_q[ln_s6.q]);
	assign sz8  = blk(tone_bits_q[ln_s7.q]);
	assign sz9  = blk(tone_bits_q[ln_s8.q]);
	assign sz10 = blk(tone_bits_q[ln_s9.q]);

	always_ff @(posedge clk) begin
		// s1: checks, segment split
		if (en[1]) begin
			ln_s1.q   <= in_q;
			ln_s1.sub <= in_sub;
			ln_s1.err <= !cfg_ok || ({1'b0, in_q} >= stream_count_q) || (in_p >= in_lim);
			p_s1      <= in_sub ? 13'(in_p - (in_lim >> 1)) : in_p;
		end
		// s2: tone number within the segment
		if (en[2]) begin
			ln_s2 <= ln_s1;
			p_s2  <= p_s1;
			u_s2  <= div_const(p_s1, b2);
		end
		// s3: bit within tone, row split by distance
		if (en[3]) begin
			ln_s3  <= ln_s2;
			p_s3   <= p_s2;
			u_s3   <= u_s2;
			bit_s3 <= 4'(p_s2 - 13'(u_s2 * b3));
			ud_s3  <= div_const(u_s2, tone_dist);
		end
		if (en[4]) begin
			ln_s4  <= ln_s3;
			p_s4   <= p_s3;
			ud_s4  <= ud_s3;
			bit_s4 <= bit_s3;
			um_s4  <= 4'(u_s3 - 13'(ud_s3 * tone_dist));
		end
		// s5: tone before mapping
		if (en[5]) begin
			ln_s5  <= ln_s4;
			p_s5   <= p_s4;
			bit_s5 <= bit_s4;
			t_s5   <= 13'(um_s4 * cols + ud_s4);
		end
		// s6: bit position before tone mapping (HT passes through)
		if (en[6]) begin
			ln_s6 <= ln_s5;
			j_s6  <= (band_mode_q == BAND_HT) ? p_s5 : 13'(t_s5 * b6 + bit_s5);
		end
		// s7/s8: undo segment parser (VHT160; other bands pass through)
		if (en[7]) begin
			ln_s7 <= ln_s6;
			j_s7  <= j_s6;
			js_s7 <= div_const(j_s6, {1'b0, sz7});
		end
		if (en[8]) begin
			ln_s8 <= ln_s7;
			if (band_mode_q == BAND_VHT160)
				k_s8 <= 13'({js_s7, 1'b0} * sz8 + (ln_s7.sub ? sz8 : 3'd0) +
					(j_s7 - 13'(js_s7 * sz8)));
			else
				k_s8 <= j_s7;
		end
		// s9/s10: undo stream parser
		if (en[9]) begin
			ln_s9 <= ln_s8;
			k_s9  <= k_s8;
			ks_s9 <= div_const(k_s8, {1'b0, sz9});
		end
		if (en[10]) begin
			ln_s10  <= ln_s9;
			idx_s10 <= ln_s9.err ? 15'd0 :
				15'(prefix[ln_s9.q] + pblock * ks_s9 + (k_s9 - 13'(ks_s9 * sz10)));
		end
	end

	assign m_tvalid = v[NS];
	assign m_tdata  = {1'b0, idx_s10};
	assign m_tuser  = ln_s10.err;

endmodule

`default_nettype wire

### bench/ldpc_stream_segment_tone_mapper_tb.sv
// ----------------------------------------------------------------------------
// ldpc_stream_segment_tone_mapper_tb
// Drives address requests through the LDPC stream/segment/tone mapper under
// several register settings and idle patterns, and checks every result
// against a behavioral predictor of the index arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldpc_stream_segment_tone_mapper_tb;
	import lsstm_pkg::*;

	localparam int LATENCY   = 10;
	localparam int CYCLE_CAP = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	ldpc_stream_segment_tone_mapper dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor's copy of the registers
	int unsigned cfg_streams;
	int unsigned cfg_bits[4];
	int unsigned cfg_band;
	int unsigned cfg_tones;

	typedef struct {
		logic [14:0] index;
		logic        err;
	} bit_addr_t;

	bit_addr_t   pending_addr[$];
	int          errors = 0;
	int unsigned cycles = 0;

	// idle controls: percent of cycles idle, plus one long receiver hold-off
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	int unsigned hold_cycles = 0;

	function automatic int unsigned stream_blk(int unsigned b);
		return (b / 2 < 1) ? 1 : b / 2;
	endfunction

	function automatic int unsigned detone(int unsigned p, int unsigned b,
			int unsigned tones, int unsigned tone_dist);
		int unsigned u;
		u = p / b;
		return (((u % tone_dist) * (tones / tone_dist) + u / tone_dist) * b) + p % b;
	endfunction

	function automatic bit_addr_t predict_addr(int unsigned q, int unsigned p);
		bit_addr_t   r;
		bit          ok;
		int unsigned prefix, pblock, tone_dist, b, s, k, half, sub, j;
		ok = 1;
		prefix = 0;
		pblock = 0;
		tone_dist = 0;
		if (cfg_streams < 1 || cfg_streams > MAX_STREAMS) ok = 0;
		if (ok) begin
			for (int i = 0; i < cfg_streams; i++) begin
				if (!(cfg_bits[i] inside {1, 2, 4, 6, 8, 10})) ok = 0;
				else begin
					if (i < q) prefix += stream_blk(cfg_bits[i]);
					pblock += stream_blk(cfg_bits[i]);
				end
			end
		end
		if (q >= cfg_streams) ok = 0;
		if (cfg_tones < 1 || cfg_tones > MAX_DATA_TONES) ok = 0;
		case (cfg_band)
			BAND_HT:     tone_dist = 0;
			BAND_VHT20:  tone_dist = 4;
			BAND_VHT40:  tone_dist = 6;
			BAND_VHT80,
			BAND_VHT160: tone_dist = 9;
			default:     ok = 0;
		endcase
		if (ok && cfg_band >= BAND_VHT20 && cfg_band <= BAND_VHT80 &&
				cfg_tones % tone_dist != 0)
			ok = 0;
		if (ok && cfg_band == BAND_VHT160 && (cfg_tones % 2 != 0 || (cfg_tones / 2) % 9 != 0))
			ok = 0;
		b = cfg_bits[q];
		if (ok && p >= cfg_tones * b) ok = 0;
		if (!ok) begin
			r.index = '0;
			r.err = 1'b1;
			return r;
		end
		s = stream_blk(b);
		if (cfg_band == BAND_HT) k = p;
		else if (cfg_band == BAND_VHT160) begin
			// two 80 MHz halves, interleaved s bits at a time
			half = cfg_tones * b / 2;
			sub = (p >= half) ? 1 : 0;
			j = detone(p - sub * half, b, cfg_tones / 2, tone_dist);
			k = 2 * s * (j / s) + sub * s + j % s;
		end else k = detone(p, b, cfg_tones, tone_dist);
		r.index = 15'(prefix + pblock * (k / s) + k % s);
		r.err = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stalls and a long hold-off counted here
	always @(posedge clk) begin
		if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// result checker
	always @(posedge clk) begin
		bit_addr_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_addr.size() == 0) begin
				report_mismatch("unexpected transfer", m_tdata, 0);
			end else begin
				want = pending_addr.pop_front();
				if (m_tdata[14:0] !== want.index)
					report_mismatch("source_index", m_tdata[14:0], want.index);
				if (m_tuser !== want.err)
					report_mismatch("mapping_error", m_tuser, want.err);
				if (m_tdata[15] !== 1'b0)
					report_mismatch("tdata pad", m_tdata[15], 0);
			end
		end
	end

	task automatic reg_write(reg_idx_t idx, int unsigned val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(4 * idx);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_STREAM_COUNT: cfg_streams = val & 7;
			REG_TONE_BITS0:   cfg_bits[0] = val & 15;
			REG_TONE_BITS1:   cfg_bits[1] = val & 15;
			REG_TONE_BITS2:   cfg_bits[2] = val & 15;
			REG_TONE_BITS3:   cfg_bits[3] = val & 15;
			REG_BAND_MODE:    cfg_band = val & 7;
			default:          cfg_tones = val & 511;
		endcase
	endtask

	task automatic set_mode(int unsigned n, int unsigned b0, int unsigned b1,
			int unsigned b2, int unsigned b3, int unsigned band, int unsigned tones);
		reg_write(REG_STREAM_COUNT, n);
		reg_write(REG_TONE_BITS0, b0);
		reg_write(REG_TONE_BITS1, b1);
		reg_write(REG_TONE_BITS2, b2);
		reg_write(REG_TONE_BITS3, b3);
		reg_write(REG_BAND_MODE, band);
		reg_write(REG_DATA_TONES, tones);
	endtask

	// one request transfer; valid held across back-to-back items
	task automatic send_req(int unsigned q, int unsigned p);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, 13'(p), 2'(q)};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_addr.insert(pending_addr.size(), predict_addr(q, p));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_addr.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// random requests: mostly in-range positions, some anywhere in the field
	task automatic random_reqs(int count);
		int unsigned q, p, lim;
		for (int i = 0; i < count; i++) begin
			q = $urandom_range(cfg_streams > 4 || cfg_streams == 0 ? 3 : cfg_streams - 1);
			if ($urandom_range(9) == 0) q = $urandom_range(3);
			lim = cfg_tones * cfg_bits[q];
			if (lim == 0 || $urandom_range(9) == 0) p = $urandom_range(8191);
			else p = $urandom_range(lim - 1);
			send_req(q, p);
		end
		drain();
	endtask

	typedef struct {
		int unsigned q;
		int unsigned p;
		bit          fixed;
		logic [14:0] index;
		logic        err;
	} dir_row_t;

	// directed rows under reset settings (1 stream, 1 bit, VHT20, 52 tones)
	dir_row_t dir_rows[] = '{
		'{0, 0,    1, 15'd0, 1'b0},   // first tone
		'{0, 1,    1, 15'd13, 1'b0},  // second tone maps one column over
		'{0, 51,   0, 15'd0, 1'b0},   // last position
		'{0, 52,   1, 15'd0, 1'b1},   // position out of range
		'{0, 8191, 1, 15'd0, 1'b1},   // position field all ones
		'{1, 0,    1, 15'd0, 1'b1},   // stream not in use
		'{3, 7,    1, 15'd0, 1'b1},
		'{0, 4,    0, 15'd0, 1'b0},
		'{0, 27,   0, 15'd0, 1'b0}
	};

	initial begin
		bit_addr_t want;
		cfg_streams = 1;
		cfg_bits = '{1, 1, 1, 1};
		cfg_band = BAND_VHT20;
		cfg_tones = 52;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_req(dir_rows[i].q, dir_rows[i].p);
			if (dir_rows[i].fixed) begin
				want = predict_addr(dir_rows[i].q, dir_rows[i].p);
				if (want.index !== dir_rows[i].index || want.err !== dir_rows[i].err)
					report_mismatch("directed table row", i, 0);
				pending_addr[pending_addr.size() - 1].index = dir_rows[i].index;
				pending_addr[pending_addr.size() - 1].err = dir_rows[i].err;
			end
		end
		drain();

		// extremes and every band: 4 streams, max bits, VHT160 at 468 tones
		set_mode(4, 10, 10, 10, 10, BAND_VHT160, 468);
		send_req(3, 4679);
		send_req(0, 0);
		send_req(2, 2340);
		send_req(3, 4680);               // out of range
		drain();
		set_mode(4, 1, 2, 6, 8, BAND_VHT80, 234);
		random_reqs(5);
		set_mode(3, 4, 1, 3, 6, BAND_VHT40, 108);   // bad tone bits on a used stream
		send_req(0, 0);
		drain();
		set_mode(0, 1, 1, 1, 1, BAND_HT, 1);        // zero streams
		send_req(0, 0);
		drain();
		set_mode(7, 1, 1, 1, 1, BAND_HT, 1);        // too many streams
		send_req(0, 0);
		drain();
		set_mode(2, 2, 2, 1, 1, 7, 52);             // bad band mode
		send_req(1, 3);
		drain();
		set_mode(1, 2, 1, 1, 1, BAND_VHT20, 0);     // zero tones
		send_req(0, 0);
		drain();
		set_mode(1, 2, 1, 1, 1, BAND_VHT20, 511);   // too many tones
		send_req(0, 0);
		drain();
		set_mode(1, 2, 1, 1, 1, BAND_VHT20, 50);    // tone count not a multiple
		send_req(0, 0);
		drain();
		set_mode(1, 2, 1, 1, 1, BAND_VHT160, 90);   // halves of 45 tones, a multiple of 9
		send_req(0, 1);
		drain();
		set_mode(2, 4, 6, 1, 1, BAND_HT, 467);      // HT takes any tone count
		send_req(1, 2801);
		drain();

		// random phases over settings and idle patterns
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_idle = 0;  end
				1: begin send_idle = 65; recv_idle = 0;  end
				2: begin send_idle = 0;  recv_idle = 65; end
				default: begin send_idle = 30; recv_idle = 30; end
			endcase
			case (ph % 6)
				0: set_mode(4, 10, 8, 6, 4, BAND_VHT160, 468);
				1: set_mode(1, 1, 2, 4, 6, BAND_VHT20, 52);
				2: set_mode(2, 6, 2, 10, 1, BAND_VHT40, 108);
				3: set_mode(3, 4, 8, 1, 10, BAND_VHT80, 234);
				4: set_mode(4, 2, 2, 2, 2, BAND_HT, 56);
				default: set_mode($urandom_range(7), $urandom_range(15), $urandom_range(15),
					$urandom_range(15), $urandom_range(15), $urandom_range(7),
					$urandom_range(511));
			endcase
			if (ph == 0) hold_cycles = 200;   // long stall to back up the pipeline
			random_reqs(42);
		end

		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### ldpc_stream_segment_tone_mapper.f
hw/rtl/lsstm_pkg.sv
hw/rtl/ldpc_stream_segment_tone_mapper.sv
bench/ldpc_stream_segment_tone_mapper_tb.sv
